// ----- hdl/gpr_pkg.sv -----
// Package for the GPIO port register block.
// Holds the pin count, the register selector codes and the request, response
// and pin view structures. No dependencies.
package gpr_pkg;

	// Number of implemented pins, from 16 to 32.
	localparam int PIN_COUNT = 32;
	localparam int PIN_W = $clog2(PIN_COUNT);
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] IMPL_PINS = ALL_ONES >> (32 - PIN_COUNT);

	// Register selector codes.
	typedef enum logic [3:0] {
		SEL_DIR      = 4'd0,
		SEL_DIRCLR   = 4'd1,
		SEL_DIRSET   = 4'd2,
		SEL_OUT      = 4'd3,
		SEL_OUTCLR   = 4'd4,
		SEL_OUTSET   = 4'd5,
		SEL_OUTTGL   = 4'd6,
		SEL_IN       = 4'd7,
		SEL_CTRL     = 4'd8,
		SEL_WRCONFIG = 4'd9,
		SEL_PINCFG   = 4'd10,
		SEL_PMUX     = 4'd11
	} sel_t;

	// Access command codes.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// WRCONFIG word bit positions.
	localparam int WRC_PMUXEN   = 16;
	localparam int WRC_INEN     = 17;
	localparam int WRC_PULLEN   = 18;
	localparam int WRC_DRVSTR   = 22;
	localparam int WRC_PMUX_LO  = 24;
	localparam int WRC_WRPMUX   = 28;
	localparam int WRC_WRPINCFG = 30;
	localparam int WRC_HWSEL    = 31;

	// PINCFG byte bit positions.
	localparam int PCB_PMUXEN = 0;
	localparam int PCB_INEN   = 1;
	localparam int PCB_PULLEN = 2;
	localparam int PCB_DRVSTR = 6;

	// One bus access.
	typedef struct packed {
		logic        cmd;
		logic [3:0]  reg_sel;
		logic [4:0]  pin_index;
		logic [31:0] wdata;
		logic [31:0] pad_levels;
	} req_t;

	// One access result.
	typedef struct packed {
		logic [31:0] rdata;
		logic [31:0] dir_drive;
		logic [31:0] out_drive;
		logic [31:0] pull_en;
		logic [31:0] input_en;
		logic [31:0] mux_en;
		logic [31:0] drive_strong;
	} rsp_t;

	// Pin configuration as seen by the top level: vectors after the access,
	// plus the addressed pin's read values.
	typedef struct packed {
		logic [31:0] mux_en;
		logic [31:0] input_en;
		logic [31:0] pull_en;
		logic [31:0] drive_strong;
		logic [31:0] cfg_rdata;
		logic [31:0] func_rdata;
	} pin_view_t;

endpackage

// ----- hdl/gpr_pincfg.sv -----
// Per-pin configuration and peripheral function storage of the GPIO port.
// Handles PINCFG, PMUX and bulk WRCONFIG writes. Depends on gpr_pkg.
module gpr_pincfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  gpr_pkg::req_t      req,
	output gpr_pkg::pin_view_t view
);
	import gpr_pkg::*;

	logic [PIN_COUNT-1:0] mux_q, inen_q, pull_q, drv_q;
	logic [PIN_COUNT-1:0] mux_d, inen_d, pull_d, drv_d;
	logic [3:0]           func_q [PIN_COUNT];
	logic [3:0]           func_d [PIN_COUNT];
	logic                 pin_ok;
	logic                 wr;
	logic [PIN_W-1:0]     pin;

	assign pin_ok = {1'b0, req.pin_index} < 6'(PIN_COUNT);
	assign wr     = valid && (req.cmd == CMD_WRITE);
	assign pin    = req.pin_index[PIN_W-1:0];

	// Next configuration of every pin for this request.
	always_comb begin
		logic bulk_hit;
		logic pin_hit;
		mux_d  = mux_q;
		inen_d = inen_q;
		pull_d = pull_q;
		drv_d  = drv_q;
		for (int p = 0; p < PIN_COUNT; p++) begin
			func_d[p] = func_q[p];
			pin_hit  = pin_ok && (req.pin_index == 5'(p));
			bulk_hit = req.wdata[p[3:0]] && (req.wdata[WRC_HWSEL] == p[4]);
			case (sel_t'(req.reg_sel))
				SEL_WRCONFIG: begin
					if (wr && bulk_hit && req.wdata[WRC_WRPINCFG]) begin
						mux_d[p]  = req.wdata[WRC_PMUXEN];
						inen_d[p] = req.wdata[WRC_INEN];
						pull_d[p] = req.wdata[WRC_PULLEN];
						drv_d[p]  = req.wdata[WRC_DRVSTR];
					end
					if (wr && bulk_hit && req.wdata[WRC_WRPMUX]) begin
						func_d[p] = req.wdata[WRC_PMUX_LO +: 4];
					end
				end
				SEL_PINCFG: begin
					if (wr && pin_hit) begin
						mux_d[p]  = req.wdata[PCB_PMUXEN];
						inen_d[p] = req.wdata[PCB_INEN];
						pull_d[p] = req.wdata[PCB_PULLEN];
						drv_d[p]  = req.wdata[PCB_DRVSTR];
					end
				end
				SEL_PMUX: begin
					if (wr && pin_hit) begin
						func_d[p] = req.wdata[3:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_q  <= '0;
			inen_q <= '0;
			pull_q <= '0;
			drv_q  <= '0;
			for (int p = 0; p < PIN_COUNT; p++) begin
				func_q[p] <= '0;
			end
		end else begin
			mux_q  <= mux_d;
			inen_q <= inen_d;
			pull_q <= pull_d;
			drv_q  <= drv_d;
			for (int p = 0; p < PIN_COUNT; p++) begin
				func_q[p] <= func_d[p];
			end
		end
	end

	// Vectors after the access and the addressed pin's read values.
	always_comb begin
		view.mux_en       = 32'(mux_d);
		view.input_en     = 32'(inen_d);
		view.pull_en      = 32'(pull_d);
		view.drive_strong = 32'(drv_d);
		view.cfg_rdata    = '0;
		view.func_rdata   = '0;
		if (pin_ok) begin
			view.cfg_rdata[PCB_PMUXEN] = mux_q[pin];
			view.cfg_rdata[PCB_INEN]   = inen_q[pin];
			view.cfg_rdata[PCB_PULLEN] = pull_q[pin];
			view.cfg_rdata[PCB_DRVSTR] = drv_q[pin];
			view.func_rdata[3:0]       = func_q[pin];
		end
	end

endmodule

// ----- hdl/gpio_port_register_block.sv -----
// Top level of the GPIO port register block.
// Holds the direction, output and control latches and the read multiplexer;
// instantiates gpr_pincfg. Depends on gpr_pkg.
//
// Each bus request is taken when start is high and busy is low; busy is
// always low, so a request may be given in every cycle. The request is
// registered, decoded and applied in the following cycle, and its response
// is then registered onto rsp, with done high for exactly one cycle. The
// response carries the read data (zero for writes) and the pin control
// vectors as they stand after the access. The receiver must take every
// response in the cycle it is shown: there is no stall.
module gpio_port_register_block (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  gpr_pkg::req_t req,
	output logic          done,
	output gpr_pkg::rsp_t rsp
);
	import gpr_pkg::*;

	req_t        req_s1;
	logic        valid_s1;
	logic [31:0] dir_q, out_q, ctrl_q;
	logic [31:0] dir_d, out_d, ctrl_d;
	logic [31:0] rdata;
	logic [31:0] m;
	logic        wr;
	pin_view_t   view;

	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	gpr_pincfg u_pincfg (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.req    (req_s1),
		.view   (view)
	);

	assign wr = valid_s1 && (req_s1.cmd == CMD_WRITE);
	assign m  = req_s1.wdata & IMPL_PINS;

	// Latch updates and read data.
	always_comb begin
		dir_d  = dir_q;
		out_d  = out_q;
		ctrl_d = ctrl_q;
		rdata  = '0;
		if (wr) begin
			case (sel_t'(req_s1.reg_sel))
				SEL_DIR:    dir_d  = m;
				SEL_DIRCLR: dir_d  = dir_q & ~m;
				SEL_DIRSET: dir_d  = dir_q | m;
				SEL_OUT:    out_d  = m;
				SEL_OUTCLR: out_d  = out_q & ~m;
				SEL_OUTSET: out_d  = out_q | m;
				SEL_OUTTGL: out_d  = out_q ^ m;
				SEL_CTRL:   ctrl_d = m;
				default: begin
				end
			endcase
		end else begin
			case (sel_t'(req_s1.reg_sel))
				SEL_DIR, SEL_DIRCLR, SEL_DIRSET: rdata = dir_q;
				SEL_OUT, SEL_OUTCLR, SEL_OUTSET, SEL_OUTTGL: rdata = out_q;
				SEL_IN:     rdata = req_s1.pad_levels & view.input_en;
				SEL_CTRL:   rdata = ctrl_q;
				SEL_PINCFG: rdata = view.cfg_rdata;
				SEL_PMUX:   rdata = view.func_rdata;
				default:    rdata = '0;
			endcase
		end
	end

	// Port latches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= '0;
			out_q  <= '0;
			ctrl_q <= '0;
		end else begin
			dir_q  <= dir_d;
			out_q  <= out_d;
			ctrl_q <= ctrl_d;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp.rdata        <= rdata;
			rsp.dir_drive    <= dir_d;
			rsp.out_drive    <= out_d;
			rsp.pull_en      <= view.pull_en;
			rsp.input_en     <= view.input_en;
			rsp.mux_en       <= view.mux_en;
			rsp.drive_strong <= view.drive_strong;
		end
	end

endmodule
